[rtl/core/hashed_block_buffer_cache_unit_defines.svh]
// Assertion macros used by the buffer cache back end.
`ifndef HASHED_BLOCK_BUFFER_CACHE_UNIT_DEFINES_SVH
`define HASHED_BLOCK_BUFFER_CACHE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HBBC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define HBBC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/hbbc_pkg.sv]
// Types and constants of the hashed block buffer cache.
package hbbc_pkg;

	// command codes
	typedef enum logic [1:0] {
		CMD_GET     = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_PIN     = 2'd2,
		CMD_UNPIN   = 2'd3
	} cmd_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NO_FREE   = 2'd1,
		STAT_UNDERFLOW = 2'd2,
		STAT_SATURATED = 2'd3
	} status_t;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	// one request item
	typedef struct packed {
		cmd_t        cmd;
		logic [7:0]  dev;
		logic [31:0] blk;
		logic [2:0]  way;
	} req_t;

	// bookkeeping of one way
	typedef struct packed {
		logic [7:0]  dev;
		logic [31:0] blk;
		logic        cv;
		logic [15:0] cnt;
		logic [2:0]  rank;
	} way_t;

endpackage

[rtl/core/hashed_block_buffer_cache_unit.sv]
// Top level of the hashed block buffer cache.
// Input channel: in_valid/in_stall with cmd, device_id, block_number,
// way_index; an item is taken when in_valid is high and in_stall low.
// Output channel: out_valid/out_stall with one result item per input
// item, in order: bucket_index, way_used, hit, needs_fill, status, ref_count.
// The front computes the bucket in a two-stage pipeline and feeds a
// two-entry queue. The back takes one item at a time: it reads the
// bucket row from the bucket memory, then updates and writes it back
// and pops no new item until that write is done. An accepted item
// passes the front stages, queue, row read and result register.
// When the receiver stalls, the result register holds; the back keeps
// one more item read and waiting, the queue and front fill, then
// in_stall rises.
// Reset empties the pipeline and queue; every bucket reads as its reset
// contents through per-row valid bits, so no clearing pass is needed.
module hashed_block_buffer_cache_unit #(
	parameter int NUM_BUCKETS = 13,
	parameter int WAYS        = 5,
	localparam int BKT_W      = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       cmd,
	input  logic [7:0]       device_id,
	input  logic [31:0]      block_number,
	input  logic [2:0]       way_index,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [BKT_W-1:0] bucket_index,
	output logic [2:0]       way_used,
	output logic             hit,
	output logic             needs_fill,
	output logic [1:0]       status,
	output logic [15:0]      ref_count
);

	localparam int DW = $bits(hbbc_pkg::req_t) + BKT_W;

	hbbc_pkg::req_t   in_req, f_req, q_req;
	logic             f_push, q_full, q_pop, q_empty;
	logic [BKT_W-1:0] f_bkt, q_bkt;
	logic [DW-1:0]    q_data;

	assign in_req = '{cmd: hbbc_pkg::cmd_t'(cmd), dev: device_id,
	                  blk: block_number, way: way_index};

	hbbc_front #(.NUM_BUCKETS(NUM_BUCKETS), .BKT_W(BKT_W)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_req,
		.push(f_push), .push_req(f_req), .push_bucket(f_bkt), .full(q_full)
	);

	hbbc_queue #(.DW(DW)) u_queue (
		.clk, .arst_n, .push(f_push), .push_data({f_req, f_bkt}), .full(q_full),
		.pop(q_pop), .pop_data(q_data), .empty(q_empty)
	);

	assign q_req = q_data[DW-1:BKT_W];
	assign q_bkt = q_data[BKT_W-1:0];

	hbbc_back #(.NUM_BUCKETS(NUM_BUCKETS), .WAYS(WAYS), .BKT_W(BKT_W)) u_back (
		.clk, .arst_n, .empty(q_empty), .pop(q_pop), .pop_req(q_req),
		.pop_bucket(q_bkt), .out_valid, .out_stall, .bucket_index, .way_used,
		.hit, .needs_fill, .status, .ref_count
	);

endmodule

[rtl/core/hbbc_front.sv]
// Front end: accepts items and computes the bucket (block number mod bucket count).
module hbbc_front #(
	parameter int NUM_BUCKETS = 13,
	parameter int BKT_W       = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  hbbc_pkg::req_t     in_req,
	output logic               push,
	output hbbc_pkg::req_t     push_req,
	output logic [BKT_W-1:0]   push_bucket,
	input  logic               full
);

	// 2^16 mod N folds the high half; reciprocal is exact for 23-bit dividends
	localparam int    P16   = 65536 % NUM_BUCKETS;
	localparam longint RECIP = ((64'd1 << 29) + NUM_BUCKETS - 1) / NUM_BUCKETS;

	logic [5:0]  p16;
	logic [29:0] recip;
	assign p16   = 6'(P16);
	assign recip = 30'(RECIP);

	logic           v_s1, v_s2;
	hbbc_pkg::req_t req_s1, req_s2;
	logic [22:0]    y_s1, y_s2;
	logic [22:0]    q_s2;
	logic           rdy_s1, rdy_s2;
	logic [52:0]    prod;
	logic [22:0]    rem;
	logic [22:0]    y_d;

	// stage handshake
	assign rdy_s2   = !v_s2 || !full;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;
	assign push     = v_s2 && !full;

	// fold high half into low half
	assign y_d = 23'(in_req.blk[31:16]) * 23'(p16) + 23'(in_req.blk[15:0]);

	// quotient by reciprocal
	assign prod = 53'(y_s1) * 53'(recip);

	// remainder with one correction step
	always_comb begin
		rem = y_s2 - 23'(q_s2 * 23'(NUM_BUCKETS));
		if (rem >= 23'(NUM_BUCKETS)) begin
			rem = rem - 23'(NUM_BUCKETS);
		end
	end

	assign push_req    = req_s2;
	assign push_bucket = BKT_W'(rem);

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			req_s1 <= in_req;
			y_s1   <= y_d;
		end
		if (rdy_s2) begin
			req_s2 <= req_s1;
			y_s2   <= y_s1;
			q_s2   <= prod[51:29];
		end
	end

endmodule

[rtl/core/hbbc_queue.sv]
// Two-entry queue between front and back.
module hbbc_queue #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] push_data,
	output logic          full,
	input  logic          pop,
	output logic [DW-1:0] pop_data,
	output logic          empty
);

	logic [DW-1:0] mem_q [2];
	logic          wptr_q, rptr_q;
	logic [1:0]    cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_data = mem_q[rptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (pop)  rptr_q <= !rptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= push_data;
	end

endmodule

[rtl/core/hbbc_back.sv]
// Back end: reads a bucket row, executes the command, writes the row back.
`include "hashed_block_buffer_cache_unit_defines.svh"
module hbbc_back #(
	parameter int NUM_BUCKETS = 13,
	parameter int WAYS        = 5,
	parameter int BKT_W       = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             empty,
	output logic             pop,
	input  hbbc_pkg::req_t   pop_req,
	input  logic [BKT_W-1:0] pop_bucket,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [BKT_W-1:0] bucket_index,
	output logic [2:0]       way_used,
	output logic             hit,
	output logic             needs_fill,
	output logic [1:0]       status,
	output logic [15:0]      ref_count
);

	localparam int WI = (WAYS > 1) ? $clog2(WAYS) : 1;

	typedef enum logic {S_IDLE, S_EXEC} state_t;

	state_t                          state_q;
	hbbc_pkg::way_t [WAYS-1:0]       mem_q [NUM_BUCKETS];
	logic [NUM_BUCKETS-1:0]          rowv_q;
	logic                            rdv_q;
	hbbc_pkg::way_t [WAYS-1:0]       rd_row_q;
	hbbc_pkg::req_t                  cur_q;
	logic [BKT_W-1:0]                bkt_q;
	logic                            out_valid_q;
	logic                            commit;

	hbbc_pkg::way_t [WAYS-1:0]       row, new_row;
	logic [2:0]                      o_way;
	logic                            o_hit, o_fill;
	hbbc_pkg::status_t               o_st;
	logic [15:0]                     o_cnt;

	assign pop       = (state_q == S_IDLE) && !empty;
	assign commit    = (state_q == S_EXEC) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	// row as read, or reset contents for a row never written
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			if (rdv_q) begin
				row[w] = rd_row_q[w];
			end else begin
				row[w] = hbbc_pkg::way_t'{dev: 8'd0, blk: 32'd0, cv: 1'b0, cnt: 16'd0,
				                          rank: 3'(WAYS - 1 - w)};
			end
		end
	end

	// command execution
	always_comb begin
		logic          hf, ff;
		logic [WI-1:0] sel;
		logic [2:0]    best;
		logic [WI-1:0] aw;
		logic [15:0]   c;
		new_row = row;
		o_way   = 3'd0;
		o_hit   = 1'b0;
		o_fill  = 1'b0;
		o_st    = hbbc_pkg::STAT_OK;
		o_cnt   = 16'd0;
		hf      = 1'b0;
		ff      = 1'b0;
		sel     = '0;
		best    = 3'd0;
		aw      = cur_q.way[WI-1:0];
		c       = 16'd0;
		if (cur_q.cmd == hbbc_pkg::CMD_GET) begin
			// most recent matching tag
			for (int w = 0; w < WAYS; w++) begin
				if (row[w].dev == cur_q.dev && row[w].blk == cur_q.blk &&
				    (!hf || row[w].rank < best)) begin
					hf   = 1'b1;
					sel  = WI'(w);
					best = row[w].rank;
				end
			end
			if (hf) begin
				o_hit = 1'b1;
				if (row[sel].cnt == hbbc_pkg::COUNT_MAX) begin
					o_st = hbbc_pkg::STAT_SATURATED;
				end else begin
					new_row[sel].cnt = row[sel].cnt + 16'd1;
				end
			end else begin
				// least recent way with no holders
				for (int w = 0; w < WAYS; w++) begin
					if (row[w].cnt == 16'd0 && (!ff || row[w].rank > best)) begin
						ff   = 1'b1;
						sel  = WI'(w);
						best = row[w].rank;
					end
				end
				if (ff) begin
					new_row[sel].dev = cur_q.dev;
					new_row[sel].blk = cur_q.blk;
					new_row[sel].cv  = 1'b0;
					new_row[sel].cnt = 16'd1;
				end else begin
					o_st = hbbc_pkg::STAT_NO_FREE;
				end
			end
			if (hf || ff) begin
				o_way           = 3'(sel);
				o_fill          = !new_row[sel].cv;
				new_row[sel].cv = 1'b1;
				o_cnt           = new_row[sel].cnt;
			end
		end else if ({1'b0, cur_q.way} >= 4'(WAYS)) begin
			o_way = cur_q.way;
		end else begin
			o_way = cur_q.way;
			c     = row[aw].cnt;
			case (cur_q.cmd)
				hbbc_pkg::CMD_PIN: begin
					if (c == hbbc_pkg::COUNT_MAX) o_st = hbbc_pkg::STAT_SATURATED;
					else new_row[aw].cnt = c + 16'd1;
				end
				hbbc_pkg::CMD_RELEASE, hbbc_pkg::CMD_UNPIN: begin
					if (c == 16'd0) begin
						o_st = hbbc_pkg::STAT_UNDERFLOW;
					end else begin
						new_row[aw].cnt = c - 16'd1;
						// release to zero makes the way newest
						if (cur_q.cmd == hbbc_pkg::CMD_RELEASE && c == 16'd1) begin
							for (int w = 0; w < WAYS; w++) begin
								if (row[w].rank < row[aw].rank) begin
									new_row[w].rank = row[w].rank + 3'd1;
								end
							end
							new_row[aw].rank = 3'd0;
						end
					end
				end
				default: ;
			endcase
			o_cnt = new_row[aw].cnt;
		end
	end

	// sequencer, row valid bits and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rowv_q      <= '0;
			rdv_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						state_q <= S_EXEC;
						rdv_q   <= rowv_q[pop_bucket];
					end
				end
				S_EXEC: begin
					if (commit) begin
						state_q        <= S_IDLE;
						rowv_q[bkt_q]  <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (commit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// bucket memory with registered read
	always_ff @(posedge clk) begin
		if (pop) begin
			rd_row_q <= mem_q[pop_bucket];
			cur_q    <= pop_req;
			bkt_q    <= pop_bucket;
		end
		if (commit) mem_q[bkt_q] <= new_row;
	end

	// result register
	always_ff @(posedge clk) begin
		if (commit) begin
			bucket_index <= bkt_q;
			way_used     <= o_way;
			hit          <= o_hit;
			needs_fill   <= o_fill;
			status       <= o_st;
			ref_count    <= o_cnt;
		end
	end

	`HBBC_ASSERT_NEXT(a_pop_exec, pop, state_q == S_EXEC, "pop did not start execution")
	`HBBC_ASSERT_NEXT(a_commit_out, commit, out_valid_q, "commit lost its result")
	`HBBC_ASSERT_NOW(a_nofree_zero, out_valid_q && status == hbbc_pkg::STAT_NO_FREE, !hit && !needs_fill && ref_count == 16'd0, "no-free result not cleared")
	`HBBC_ASSERT_NOW(a_hit_status, out_valid_q && hit, status == hbbc_pkg::STAT_OK || status == hbbc_pkg::STAT_SATURATED, "hit with bad status")

endmodule
